>>> src/dfr_pkg.sv
// ---------------------------------------------------------------------------
// dfr_pkg: shared types and constants of the dle frame receiver
// link event and result request layouts, event classes, codes and limits
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

  // widths fixed by the request layouts
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned CFG_IDX_W = 2;

  // hard limit on bytes stored per frame
  localparam int unsigned MAX_FRAME_BYTES = 512;
  localparam logic [COUNT_W-1:0] CAP_MAX = COUNT_W'(MAX_FRAME_BYTES);
  localparam logic [COUNT_W-1:0] CAP_MIN = COUNT_W'(1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END      = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0]  CAPACITY_RST = 10'd512;
  localparam logic [BYTE_W-1:0] ESCAPE_RST   = 8'h10;
  localparam logic [BYTE_W-1:0] END_RST      = 8'h03;

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd1;

  // report status codes
  localparam logic [STAT_W-1:0] ST_GOOD      = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SUM   = 3'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [STAT_W-1:0] ST_TIMEOUT   = 3'd3;
  localparam logic [STAT_W-1:0] ST_ERROR     = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               is_end;
    logic [BYTE_W-1:0]  payload_byte;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] frame_length;
    logic               length_mismatch;
  } out_item_t;

  typedef enum logic [1:0] {
    EV_BYTE,
    EV_TIMEOUT,
    EV_ERROR
  } ev_class_t;

  // classified link event, as queued between front and back
  typedef struct packed {
    ev_class_t         cls;
    logic              esc_hit;
    logic              end_hit;
    logic [BYTE_W-1:0] data;
  } event_t;

endpackage

`default_nettype wire

>>> src/dfr_front.sv
// ---------------------------------------------------------------------------
// dfr_front: link event classifier
// sorts each request by kind and matches the byte against dle and etx codes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfr_front (
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire dfr_pkg::in_item_t            in_item,
  input  wire logic [dfr_pkg::BYTE_W-1:0]   escape_code,
  input  wire logic [dfr_pkg::BYTE_W-1:0]   end_code,
  output logic                              push_valid,
  input  wire logic                         push_ready,
  output dfr_pkg::event_t                   push_event
);

  always_comb begin
    push_event.data    = in_item.rx_byte;
    push_event.esc_hit = (in_item.rx_byte == escape_code);
    push_event.end_hit = (in_item.rx_byte == end_code);
    unique case (in_item.kind)
      dfr_pkg::KIND_BYTE:    push_event.cls = dfr_pkg::EV_BYTE;
      dfr_pkg::KIND_TIMEOUT: push_event.cls = dfr_pkg::EV_TIMEOUT;
      // unused kind code is handled as a link error
      default:               push_event.cls = dfr_pkg::EV_ERROR;
    endcase
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

`default_nettype wire

>>> src/dfr_queue.sv
// ---------------------------------------------------------------------------
// dfr_queue: two-entry event queue
// decouples the classifier from the frame engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfr_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire dfr_pkg::event_t push_event,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output dfr_pkg::event_t      pop_event
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dfr_pkg::event_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_event  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/dfr_back.sv
// ---------------------------------------------------------------------------
// dfr_back: frame engine
// unstuffs, sums and counts frame bytes and drives the result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfr_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          pop_valid,
  output logic                               pop_ready,
  input  wire dfr_pkg::event_t               pop_event,
  input  wire logic [dfr_pkg::COUNT_W-1:0]   capacity,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output dfr_pkg::out_item_t                 out_item
);

  typedef enum logic {
    S_HUNT,
    S_FRAME
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            esc_pending_r, esc_pending_nxt;
  logic [dfr_pkg::BYTE_W-1:0]      sum_r, sum_nxt;
  logic [dfr_pkg::COUNT_W-1:0]     stored_r, stored_nxt;
  logic [dfr_pkg::BYTE_W-1:0]      decl_len_r, decl_len_nxt;
  logic                            len_taken_r, len_taken_nxt;
  logic [dfr_pkg::BYTE_W-1:0]      held_byte_r, held_byte_nxt;
  logic                            held_valid_r, held_valid_nxt;
  logic                            out_valid_r, out_valid_nxt;
  dfr_pkg::out_item_t              out_item_r, out_item_nxt;

  logic                            go;
  logic                            emit;
  logic                            close;
  dfr_pkg::out_item_t              res;
  logic [dfr_pkg::COUNT_W-1:0]     stored_inc;
  logic [dfr_pkg::COUNT_W-1:0]     flen;
  logic [dfr_pkg::COUNT_W-1:0]     want;

  assign go         = pop_valid && (!out_valid_r || out_ready);
  assign pop_ready  = !out_valid_r || out_ready;
  assign stored_inc = stored_r + dfr_pkg::COUNT_W'(1);
  assign flen       = (stored_r == '0) ? '0 : stored_r - dfr_pkg::COUNT_W'(1);
  assign want       = len_taken_r ? {2'b00, decl_len_r} + dfr_pkg::COUNT_W'(1) : '0;

  always_comb begin
    state_nxt       = state_r;
    esc_pending_nxt = esc_pending_r;
    sum_nxt         = sum_r;
    stored_nxt      = stored_r;
    decl_len_nxt    = decl_len_r;
    len_taken_nxt   = len_taken_r;
    held_byte_nxt   = held_byte_r;
    held_valid_nxt  = held_valid_r;
    emit            = 1'b0;
    close           = 1'b0;
    res             = '0;

    unique case (state_r)
      S_HUNT: begin
        if (pop_event.cls == dfr_pkg::EV_BYTE) begin
          if (pop_event.esc_hit) begin
            state_nxt = S_FRAME;
          end
        end else begin
          emit       = 1'b1;
          close      = 1'b1;
          res.is_end = 1'b1;
          res.status = (pop_event.cls == dfr_pkg::EV_TIMEOUT) ?
                       dfr_pkg::ST_TIMEOUT : dfr_pkg::ST_ERROR;
        end
      end
      S_FRAME: begin
        if (pop_event.cls != dfr_pkg::EV_BYTE) begin
          emit       = 1'b1;
          close      = 1'b1;
          res.is_end = 1'b1;
          res.status = dfr_pkg::ST_ERROR;
        end else if (esc_pending_r && pop_event.end_hit) begin
          emit                = 1'b1;
          close               = 1'b1;
          res.is_end          = 1'b1;
          res.status          = (sum_r == '0) ? dfr_pkg::ST_GOOD : dfr_pkg::ST_BAD_SUM;
          res.frame_length    = flen;
          res.length_mismatch = (stored_r == '0) || (want != flen);
        end else if (!esc_pending_r && pop_event.esc_hit) begin
          esc_pending_nxt = 1'b1;
        end else begin
          esc_pending_nxt = 1'b0;
          sum_nxt         = sum_r + pop_event.data;
          if (!len_taken_r && stored_r == dfr_pkg::COUNT_W'(1)) begin
            decl_len_nxt  = pop_event.data;
            len_taken_nxt = 1'b1;
          end else if (stored_inc >= capacity) begin
            emit       = 1'b1;
            close      = 1'b1;
            res.is_end = 1'b1;
            res.status = dfr_pkg::ST_TOO_LARGE;
          end else begin
            stored_nxt     = stored_inc;
            held_byte_nxt  = pop_event.data;
            held_valid_nxt = 1'b1;
            if (held_valid_r) begin
              emit             = 1'b1;
              res.payload_byte = held_byte_r;
            end
          end
        end
      end
      default: begin
        state_nxt = S_HUNT;
      end
    endcase

    // any report drops the frame and goes back to hunting
    if (close) begin
      state_nxt       = S_HUNT;
      esc_pending_nxt = 1'b0;
      sum_nxt         = '0;
      stored_nxt      = '0;
      decl_len_nxt    = '0;
      len_taken_nxt   = 1'b0;
      held_valid_nxt  = 1'b0;
    end

    if (go && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    out_item_nxt = (go && emit) ? res : out_item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_HUNT;
      esc_pending_r <= 1'b0;
      sum_r         <= '0;
      stored_r      <= '0;
      decl_len_r    <= '0;
      len_taken_r   <= 1'b0;
      held_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (go) begin
        state_r       <= state_nxt;
        esc_pending_r <= esc_pending_nxt;
        sum_r         <= sum_nxt;
        stored_r      <= stored_nxt;
        decl_len_r    <= decl_len_nxt;
        len_taken_r   <= len_taken_nxt;
        held_valid_r  <= held_valid_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    if (go) begin
      held_byte_r <= held_byte_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // hunting leaves no frame bookkeeping behind
  a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HUNT |-> stored_r == '0 && !held_valid_r && !len_taken_r && !esc_pending_r)
    else $error("frame state left over while hunting");

  // a held byte was counted as stored
  a_held_counted: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> stored_r != '0)
    else $error("held byte without stored count");

  // the length byte only follows the first stored byte
  a_len_after_type: assert property (@(posedge clk) disable iff (!rst_n)
    len_taken_r |-> stored_r != '0)
    else $error("length byte taken before type byte");

endmodule

`default_nettype wire

>>> src/dle_stuffed_frame_receiver_top.sv
// ---------------------------------------------------------------------------
// dle_stuffed_frame_receiver_top: dle/etx byte-stuffed frame receiver
// turns link events into unstuffed payload bytes and end-of-frame reports
// ---------------------------------------------------------------------------
// usage
//   in_*  : one link event per request (received byte, timeout, link error),
//           valid/ready handshake
//   out_* : zero or one result request per event: a payload byte passed on
//           one byte late, or an end report with status, length and
//           length-mismatch flag, valid/ready handshake
//   cfg_* : write-only register port (capacity, dle code, etx code), written
//           while no request is in flight
// throughput: one event per cycle while the result register is empty or being
//   taken; the two-entry event queue keeps input and output stalls apart
// result path: an accepted event is registered in the event queue, and its
//   result, if any, in the result register, where it waits for out_ready
// reset (synchronous, active low): the receiver hunts for a dle, the queue
//   and result register empty, registers back to 512 / 0x10 / 0x03
// output stall: a waiting result holds; events pile up in the queue and
//   in_ready drops once its two entries are full
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dle_stuffed_frame_receiver_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire dfr_pkg::in_item_t                in_item,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output dfr_pkg::out_item_t                    out_item,
  input  wire logic                             cfg_we,
  input  wire logic [dfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dfr_pkg::CFG_W-1:0]        cfg_wdata
);

  // capacity is kept already clamped to the supported range
  logic [dfr_pkg::COUNT_W-1:0] capacity_r;
  logic [dfr_pkg::BYTE_W-1:0]  escape_code_r;
  logic [dfr_pkg::BYTE_W-1:0]  end_code_r;
  logic [dfr_pkg::COUNT_W-1:0] cap_clamped;

  logic                        push_valid, push_ready;
  dfr_pkg::event_t             push_event;
  logic                        pop_valid, pop_ready;
  dfr_pkg::event_t             pop_event;

  // zero acts as one, anything above the hard limit acts as the limit
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_clamped = dfr_pkg::CAP_MIN;
    end else if (cfg_wdata > dfr_pkg::CAP_MAX) begin
      cap_clamped = dfr_pkg::CAP_MAX;
    end else begin
      cap_clamped = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r    <= dfr_pkg::CAPACITY_RST;
      escape_code_r <= dfr_pkg::ESCAPE_RST;
      end_code_r    <= dfr_pkg::END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfr_pkg::CFG_CAPACITY: capacity_r    <= cap_clamped;
        dfr_pkg::CFG_ESCAPE:   escape_code_r <= cfg_wdata[dfr_pkg::BYTE_W-1:0];
        dfr_pkg::CFG_END:      end_code_r    <= cfg_wdata[dfr_pkg::BYTE_W-1:0];
        // writes to the spare index are dropped
        default: begin
        end
      endcase
    end
  end

  // front: classify events against the dle and etx codes
  dfr_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .escape_code (escape_code_r),
    .end_code    (end_code_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_event  (push_event)
  );

  // short queue between classifier and frame engine
  dfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_event (push_event),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_event  (pop_event)
  );

  // back: frame engine with its result register
  dfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_event (pop_event),
    .capacity  (capacity_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> dv/dle_stuffed_frame_receiver_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dle_stuffed_frame_receiver_top_tb: self-checking bench of the frame receiver
// a directed table walks the hunt, escape, end and error paths at the reset
// register values, then random stuffed frames mixed with line noise run
// under six register settings; every result request is checked field by
// field against its table row or a cycle-free model of the unstuffing engine
// ---------------------------------------------------------------------------

module dle_stuffed_frame_receiver_top_tb;
  import dfr_pkg::*;

  // link event kinds the package leaves unnamed
  localparam logic [KIND_W-1:0] KIND_LINK_ERR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE    = 2'd3;

  localparam int CFG_SETTLE  = 4;     // cycles after the last result before a register write
  localparam int TAIL_CYCLES = 8;     // quiet cycles at the end of the run
  localparam int STALL_LIMIT = 5000;  // cycles without any handshake before giving up
  localparam int PHASE_ITEMS = 330;
  localparam int NUM_PHASES  = 6;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    in_item_t  ev;
    bit        typed;      // expectation given in the row itself
    bit        typed_has;  // row expects a result request
    out_item_t typed_res;
  } table_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CAPACITY;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // idle profile, changed per phase
  int send_idle_pct  = 28;
  int recv_stall_pct = 45;

  int mismatch_count = 0;
  int items_sent     = 0;
  int stall_cycles   = 0;

  out_item_t  expected_results[$];
  table_row_t directed_rows[$];
  in_item_t   link_seq[$];

  // model copy of the registers and of the frame engine state
  logic [CFG_W-1:0]   fr_capacity;
  logic [BYTE_W-1:0]  fr_escape;
  logic [BYTE_W-1:0]  fr_end;
  logic               fr_in_frame;
  logic               fr_esc_pending;
  logic [BYTE_W-1:0]  fr_sum;
  logic [COUNT_W-1:0] fr_stored;
  logic [BYTE_W-1:0]  fr_declared;
  logic               fr_len_taken;
  logic [BYTE_W-1:0]  fr_held;
  logic               fr_held_valid;

  dle_stuffed_frame_receiver_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // frame engine model
  // ---------------------------------------------------------------------------

  // drop all frame state; open selects frame or hunt
  function automatic void fr_restart(input logic open);
    fr_in_frame    = open;
    fr_esc_pending = 1'b0;
    fr_sum         = '0;
    fr_stored      = '0;
    fr_declared    = '0;
    fr_len_taken   = 1'b0;
    fr_held        = '0;
    fr_held_valid  = 1'b0;
  endfunction

  // end report; the engine always goes back to hunting after one
  function automatic out_item_t frame_report(input logic [STAT_W-1:0] st,
                                             input logic [COUNT_W-1:0] flen,
                                             input logic mism);
    out_item_t r;
    r                 = '0;
    r.is_end          = 1'b1;
    r.status          = st;
    r.frame_length    = flen;
    r.length_mismatch = mism;
    fr_restart(1'b0);
    return r;
  endfunction

  // one link event in, zero or one result request out
  function automatic bit unstuff_event(input in_item_t ev, output out_item_t res);
    logic [COUNT_W-1:0] cap;
    int                 got;
    int                 want;
    bit                 emit;
    res = '0;
    if (!fr_in_frame) begin
      if (ev.kind == KIND_BYTE) begin
        if (ev.rx_byte == fr_escape) fr_restart(1'b1);
        return 1'b0;
      end
      res = frame_report(ev.kind == KIND_TIMEOUT ? ST_TIMEOUT : ST_ERROR, '0, 1'b0);
      return 1'b1;
    end
    // any non-byte event inside a frame aborts it
    if (ev.kind != KIND_BYTE) begin
      res = frame_report(ST_ERROR, '0, 1'b0);
      return 1'b1;
    end
    if (fr_esc_pending) begin
      if (ev.rx_byte == fr_end) begin
        got  = int'(fr_stored) - 1;
        want = fr_len_taken ? int'(fr_declared) + 1 : 0;
        res  = frame_report(fr_sum == '0 ? ST_GOOD : ST_BAD_SUM,
                            got < 0 ? '0 : COUNT_W'(got), want != got);
        return 1'b1;
      end
      fr_esc_pending = 1'b0;
    end else if (ev.rx_byte == fr_escape) begin
      fr_esc_pending = 1'b1;
      return 1'b0;
    end
    fr_sum = fr_sum + ev.rx_byte;
    // second byte taken is the length byte: summed, not stored
    if (!fr_len_taken && fr_stored == COUNT_W'(1)) begin
      fr_declared  = ev.rx_byte;
      fr_len_taken = 1'b1;
      return 1'b0;
    end
    cap = (fr_capacity == '0) ? CAP_MIN : (fr_capacity > CAP_MAX ? CAP_MAX : fr_capacity);
    fr_stored = fr_stored + 1'b1;
    if (fr_stored >= cap) begin
      res = frame_report(ST_TOO_LARGE, '0, 1'b0);
      return 1'b1;
    end
    // stored bytes leave one byte late, so the checksum never leaves
    emit = fr_held_valid;
    if (emit) res.payload_byte = fr_held;
    fr_held       = ev.rx_byte;
    fr_held_valid = 1'b1;
    return emit;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void row(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b,
                              input bit typed, input bit has,
                              input logic [STAT_W-1:0] st, input logic [COUNT_W-1:0] flen,
                              input logic mism);
    table_row_t r;
    r.ev                        = in_item_t'({kind, b});
    r.typed                     = typed;
    r.typed_has                 = has;
    r.typed_res                 = '0;
    r.typed_res.is_end          = has;
    r.typed_res.status          = st;
    r.typed_res.frame_length    = flen;
    r.typed_res.length_mismatch = mism;
    directed_rows.push_back(r);
  endfunction

  // data bytes lean toward the two control codes to exercise stuffing
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(5))
      0:       return fr_escape;
      1:       return fr_end;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_byte(input logic [BYTE_W-1:0] b);
    link_seq.push_back(in_item_t'({KIND_BYTE, b}));
  endfunction

  function automatic void push_stuffed(input logic [BYTE_W-1:0] b);
    if (b == fr_escape) push_byte(fr_escape);
    push_byte(b);
  endfunction

  // one stuffed frame with random content, now and then broken
  function automatic void build_frame();
    int                n;
    int                eff_cap;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    link_seq.delete();
    // line noise before the opening dle
    repeat ($urandom_range(0, 2)) push_byte(BYTE_W'($urandom_range(0, 255)));
    eff_cap = (fr_capacity == '0) ? 1 :
              (fr_capacity > CAP_MAX ? int'(CAP_MAX) : int'(fr_capacity));
    // mostly short frames, rarely one around the capacity
    if ($urandom_range(49) == 0) n = eff_cap - 3 + $urandom_range(0, 4);
    else n = $urandom_range(0, 10);
    if (n < 0) n = 0;
    push_byte(fr_escape);
    b = pick_byte();                                   // type byte
    push_stuffed(b);
    sum = b;
    b = ($urandom_range(9) == 0) ? BYTE_W'($urandom_range(0, 255)) : BYTE_W'(n);
    push_stuffed(b);                                   // length byte
    sum = sum + b;
    for (int i = 0; i < n; i++) begin
      b = pick_byte();
      push_stuffed(b);
      sum = sum + b;
    end
    b = ($urandom_range(9) == 0) ? BYTE_W'($urandom_range(0, 255)) : BYTE_W'(0) - sum;
    push_stuffed(b);                                   // checksum
    case ($urandom_range(19))
      0:       link_seq.push_back(in_item_t'({KIND_TIMEOUT, BYTE_W'($urandom_range(0, 255))}));
      1:       link_seq.push_back(in_item_t'({KIND_W'($urandom_range(2, 3)),
                                              BYTE_W'($urandom_range(0, 255))}));
      2:       ;  // no closing pair, the next frame runs into this one
      default: begin
        push_byte(fr_escape);
        push_byte(fr_end);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one request on the input channel; the model steps when it is taken
  task automatic send_request(input in_item_t ev, input bit typed, input bit typed_has,
                              input out_item_t typed_res);
    out_item_t res;
    bit        has;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = unstuff_event(ev, res);
    if (typed) begin
      has = typed_has;
      res = typed_res;
    end
    if (has) expected_results.push_back(res);
    items_sent++;
  endtask

  // hold off the sender until every expected result has come back
  task automatic drain_results(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_CAPACITY: fr_capacity = val;
      CFG_ESCAPE:   fr_escape   = val[BYTE_W-1:0];
      CFG_END:      fr_end      = val[BYTE_W-1:0];
      default:      ;
    endcase
  endtask

  // registers change only with the block idle; frame state carries over
  task automatic set_registers(input logic [CFG_W-1:0] cap, input logic [BYTE_W-1:0] esc,
                               input logic [BYTE_W-1:0] etx);
    drain_results(CFG_SETTLE);
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_ESCAPE, CFG_W'(esc));
    write_reg(CFG_END, CFG_W'(etx));
    cfg_we <= 1'b0;
  endtask

  // receiver back-pressure follows the current profile
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // result checker: oldest expectation against each taken result request
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(input string what, input out_item_t want,
                                        input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s: expected end=%0d byte=%02h st=%0d len=%0d mism=%0d, got end=%0d byte=%02h st=%0d len=%0d mism=%0d",
               $realtime, what,
               want.is_end, want.payload_byte, want.status, want.frame_length,
               want.length_mismatch,
               got.is_end, got.payload_byte, got.status, got.frame_length,
               got.length_mismatch);
  endfunction

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result with nothing expected", '0, out_item);
      end else begin
        want = expected_results.pop_front();
        if (out_item.is_end !== want.is_end ||
            out_item.payload_byte !== want.payload_byte ||
            out_item.status !== want.status ||
            out_item.frame_length !== want.frame_length ||
            out_item.length_mismatch !== want.length_mismatch)
          note_mismatch("result mismatch", want, out_item);
      end
    end
  end

  // watchdog: too long without a handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("dle_stuffed_frame_receiver_top_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase_start;
    fr_capacity = CAPACITY_RST;
    fr_escape   = ESCAPE_RST;
    fr_end      = END_RST;
    fr_restart(1'b0);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, reset register values (dle 0x10, etx 0x03, capacity 512)
    // hunting: timeout, link error and the spare kind each report at once
    row(KIND_TIMEOUT,  8'h00, 1, 1, ST_TIMEOUT, '0, 1'b0);
    row(KIND_LINK_ERR, 8'hFF, 1, 1, ST_ERROR,   '0, 1'b0);
    row(KIND_SPARE,    8'hA5, 1, 1, ST_ERROR,   '0, 1'b0);
    // line noise while hunting is dropped
    row(KIND_BYTE, 8'hFF, 1, 0, ST_GOOD, '0, 1'b0);
    row(KIND_BYTE, 8'h00, 1, 0, ST_GOOD, '0, 1'b0);
    // dle etx with nothing stored: length saturates at zero, mismatch set
    row(KIND_BYTE, ESCAPE_RST, 1, 0, ST_GOOD, '0, 1'b0);
    row(KIND_BYTE, ESCAPE_RST, 1, 0, ST_GOOD, '0, 1'b0);
    row(KIND_BYTE, END_RST,    1, 1, ST_GOOD, '0, 1'b1);
    // good frame: type 00, length 01, escaped dle as data, checksum ef
    row(KIND_BYTE, ESCAPE_RST, 0, 0, ST_GOOD, '0, 1'b0);
    row(KIND_BYTE, 8'h00,      0, 0, ST_GOOD, '0, 1'b0);
    row(KIND_BYTE, 8'h01,      0, 0, ST_GOOD, '0, 1'b0);
    row(KIND_BYTE, ESCAPE_RST, 0, 0, ST_GOOD, '0, 1'b0);
    row(KIND_BYTE, ESCAPE_RST, 0, 0, ST_GOOD, '0, 1'b0);
    row(KIND_BYTE, 8'hEF,      0, 0, ST_GOOD, '0, 1'b0);
    row(KIND_BYTE, ESCAPE_RST, 0, 0, ST_GOOD, '0, 1'b0);
    row(KIND_BYTE, END_RST,    1, 1, ST_GOOD, 10'd2, 1'b0);
    // timeout inside a frame is an error, back to hunting
    row(KIND_BYTE,    ESCAPE_RST, 0, 0, ST_GOOD,  '0, 1'b0);
    row(KIND_BYTE,    8'hFF,      0, 0, ST_GOOD,  '0, 1'b0);
    row(KIND_TIMEOUT, 8'h00,      1, 1, ST_ERROR, '0, 1'b0);
    // end without a length byte: expected count zero, sum of ff is bad
    row(KIND_BYTE, ESCAPE_RST, 0, 0, ST_GOOD,    '0, 1'b0);
    row(KIND_BYTE, 8'hFF,      0, 0, ST_GOOD,    '0, 1'b0);
    row(KIND_BYTE, ESCAPE_RST, 0, 0, ST_GOOD,    '0, 1'b0);
    row(KIND_BYTE, END_RST,    1, 1, ST_BAD_SUM, '0, 1'b0);
    foreach (directed_rows[i])
      send_request(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].typed_has,
                   directed_rows[i].typed_res);

    // random phases: register settings sweep the extremes, idle profile rotates
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 3)
        0: begin
          send_idle_pct  = 28;
          recv_stall_pct = 45;
        end
        1: begin
          send_idle_pct  = 45;
          recv_stall_pct = 28;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (ph)
        0:       set_registers(CAPACITY_RST, ESCAPE_RST, END_RST);
        1:       set_registers(10'd1, 8'h00, 8'hFF);      // every frame too large at once
        2:       set_registers(10'd0, 8'hFF, 8'h00);      // zero capacity acts as one
        3:       set_registers(10'd1023, 8'h7E, 8'h7D);   // clamps to the hard limit
        4:       set_registers(10'd6, ESCAPE_RST, END_RST);
        default: set_registers(10'd40, 8'h55, 8'h55);     // dle doubling closes the frame
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(79) == 0) drain_results(0);
        if ($urandom_range(9) == 0) begin
          // a lone random event, any kind
          send_request(in_item_t'({KIND_W'($urandom_range(0, 3)),
                                   BYTE_W'($urandom_range(0, 255))}), 1'b0, 1'b0, '0);
        end else begin
          build_frame();
          foreach (link_seq[i]) send_request(link_seq[i], 1'b0, 1'b0, '0);
        end
      end
    end

    drain_results(TAIL_CYCLES);
    if (mismatch_count == 0) begin
      $display("dle_stuffed_frame_receiver_top_tb: done, clean");
    end else begin
      $display("dle_stuffed_frame_receiver_top_tb: done, errors");
    end
    $finish;
  end

endmodule
